// ----- src/rfpr_pkg.sv -----
// Shared types, codes and constants of the radar frame presence relay.
package rfpr_pkg;

  localparam int MAX_DATA_LEN_DEF = 40;
  localparam int TIMER_W = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [TIMER_W-1:0] ON_DELAY_RST = 16'd2000;
  localparam logic [TIMER_W-1:0] HOLD_MS_RST = 16'd2000;
  localparam logic [TIMER_W-1:0] TIMEOUT_MS_RST = 16'd150;
  localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ON_DELAY   = 2'd0,
    CFG_HOLD_MS    = 2'd1,
    CFG_TIMEOUT_MS = 2'd2
  } cfg_index_t;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [7:0] PAYLOAD_TYPE_TARGET = 8'h02;
  localparam logic [7:0] PAYLOAD_HEAD = 8'hAA;

  typedef struct packed {
    logic       accepted;
    logic [7:0] target;
  } frame_t;

  function automatic logic [7:0] header_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0: b = 8'hF4;
      2'd1: b = 8'hF3;
      2'd2: b = 8'hF2;
      default: b = 8'hF1;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] trailer_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0: b = 8'hF8;
      2'd1: b = 8'hF7;
      2'd2: b = 8'hF6;
      default: b = 8'hF5;
    endcase
    return b;
  endfunction

  function automatic logic [TIMER_W-1:0] sat_inc(input logic [TIMER_W-1:0] v);
    return (v == TIMER_MAX) ? v : v + 1'b1;
  endfunction

endpackage

// ----- src/rfpr_parser.sv -----
// Frame deframer with idle timeout, one update per processed item.
module rfpr_parser
  import rfpr_pkg::*;
#(
  parameter int MaxDataLen = MAX_DATA_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic               op,
  input  logic [7:0]         rx_byte,
  input  logic [TIMER_W-1:0] timeout_ms,
  output frame_t             frame
);

  localparam int LenW = $clog2(MaxDataLen + 1);

  typedef enum logic [1:0] {
    PH_SYNC = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2,
    PH_END  = 2'd3
  } phase_t;

  phase_t             phase, phase_next;
  logic [1:0]         header_index, header_index_next;
  logic [LenW-1:0]    byte_count, byte_count_next;
  logic [LenW-1:0]    payload_length, payload_length_next;
  logic [TIMER_W-1:0] idle_counter, idle_counter_next;
  logic [7:0]         head [3];
  logic               head_we;
  logic [LenW:0]      count_inc;

  assign count_inc = {1'b0, byte_count} + 1'b1;
  assign head_we = step && (op == OP_BYTE) && (phase == PH_DATA) &&
                   (count_inc <= (LenW + 1)'(3));

  always_comb begin
    phase_next = phase;
    header_index_next = header_index;
    byte_count_next = byte_count;
    payload_length_next = payload_length;
    idle_counter_next = idle_counter;
    frame = '0;
    if (op == OP_BYTE) begin
      idle_counter_next = '0;
      unique case (phase)
        PH_SYNC: begin
          if (rx_byte == header_byte(header_index)) begin
            if (header_index == 2'd3) begin
              phase_next = PH_LEN;
              header_index_next = '0;
              byte_count_next = '0;
            end else begin
              header_index_next = header_index + 1'b1;
            end
          end else begin
            header_index_next = (rx_byte == header_byte(2'd0)) ? 2'd1 : 2'd0;
          end
        end
        PH_LEN: begin
          if (byte_count == '0) begin
            payload_length_next = (int'(rx_byte) <= MaxDataLen) ?
                                  rx_byte[LenW-1:0] : '0;
            byte_count_next = LenW'(1);
          end else if (rx_byte != 8'd0 || payload_length == '0) begin
            phase_next = PH_SYNC;
            header_index_next = '0;
            byte_count_next = '0;
          end else begin
            phase_next = PH_DATA;
            byte_count_next = '0;
          end
        end
        PH_DATA: begin
          if (count_inc >= {1'b0, payload_length}) begin
            phase_next = PH_END;
            byte_count_next = '0;
          end else begin
            byte_count_next = count_inc[LenW-1:0];
          end
        end
        PH_END: begin
          if (rx_byte != trailer_byte(byte_count[1:0])) begin
            phase_next = PH_SYNC;
            header_index_next = '0;
            byte_count_next = '0;
          end else if (byte_count[1:0] != 2'd3) begin
            byte_count_next = count_inc[LenW-1:0];
          end else begin
            phase_next = PH_SYNC;
            header_index_next = '0;
            byte_count_next = '0;
            if (payload_length >= LenW'(3) && head[0] == PAYLOAD_TYPE_TARGET &&
                head[1] == PAYLOAD_HEAD) begin
              frame.accepted = 1'b1;
              frame.target = head[2];
            end
          end
        end
        default: begin
          phase_next = PH_SYNC;
        end
      endcase
    end else begin
      idle_counter_next = sat_inc(idle_counter);
      if (phase != PH_SYNC && idle_counter_next > timeout_ms) begin
        phase_next = PH_SYNC;
        header_index_next = '0;
        byte_count_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SYNC;
      header_index <= '0;
      byte_count <= '0;
      payload_length <= '0;
      idle_counter <= '0;
    end else if (step) begin
      phase <= phase_next;
      header_index <= header_index_next;
      byte_count <= byte_count_next;
      payload_length <= payload_length_next;
      idle_counter <= idle_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (head_we) begin
      head[byte_count[1:0]] <= rx_byte;
    end
  end

  a_accept_only_on_byte: assert property (@(posedge clk) disable iff (rst)
    frame.accepted |-> (op == OP_BYTE) && (phase == PH_END))
    else $error("frame accepted outside the trailer phase");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (byte_count < payload_length))
    else $error("payload count ran past the payload length");

  a_tick_clears_to_sync: assert property (@(posedge clk) disable iff (rst)
    step && (op == OP_TICK) && (phase != PH_SYNC) &&
    (sat_inc(idle_counter) > timeout_ms) |=> (phase == PH_SYNC) && (byte_count == '0))
    else $error("stuck parser not released by the idle timeout");

endmodule

// ----- src/rfpr_presence.sv -----
// Presence timers and relay decision.
module rfpr_presence
  import rfpr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic               op,
  input  frame_t             frame,
  input  logic [TIMER_W-1:0] on_delay,
  input  logic [TIMER_W-1:0] hold_ms,
  output logic               relay_on
);

  logic               detecting, detecting_next;
  logic [TIMER_W-1:0] since_first, since_first_next;
  logic [TIMER_W-1:0] since_last, since_last_next;
  logic               relay_state, relay_next;

  always_comb begin
    detecting_next = detecting;
    since_first_next = since_first;
    since_last_next = since_last;
    relay_next = relay_state;
    if (op == OP_BYTE) begin
      if (frame.accepted && frame.target != 8'd0) begin
        since_last_next = '0;
        if (!detecting) begin
          detecting_next = 1'b1;
          since_first_next = '0;
        end
      end
    end else if (detecting) begin
      since_first_next = sat_inc(since_first);
      since_last_next = sat_inc(since_last);
    end
    if (detecting_next) begin
      if (since_last_next >= hold_ms) begin
        detecting_next = 1'b0;
        relay_next = 1'b0;
      end else if (!relay_state && since_first_next >= on_delay) begin
        relay_next = 1'b1;
      end
    end
  end

  assign relay_on = relay_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      detecting <= 1'b0;
      since_first <= '0;
      since_last <= '0;
      relay_state <= 1'b0;
    end else if (step) begin
      detecting <= detecting_next;
      since_first <= since_first_next;
      since_last <= since_last_next;
      relay_state <= relay_next;
    end
  end

  a_relay_needs_detect: assert property (@(posedge clk) disable iff (rst)
    relay_state |-> detecting)
    else $error("relay on without an active detection");

  a_relay_rises_on_confirm: assert property (@(posedge clk) disable iff (rst)
    step && !relay_state && relay_next |=> detecting && (since_first >= on_delay))
    else $error("relay switched on before the confirm time");

endmodule

// ----- src/radar_frame_presence_relay.sv -----
// Top level of the radar frame presence relay: input stage, result stage and configuration.
// Each transfer on the input stream is a received radar byte or a one-millisecond tick, and
// each one gives exactly one result transfer carrying the relay drive and, when the byte ends
// a valid target report, the target state. An item is held in the input register,
// is processed by the deframer and presence logic on its way into the result register, and
// one item per cycle is sustained while the output side keeps taking results. Configuration
// registers are written through their own channel, which is always ready; the user must write
// them only while no item is in flight, since the block itself does not enforce this.
module radar_frame_presence_relay
  import rfpr_pkg::*;
#(
  parameter int MAX_DATA_LEN = MAX_DATA_LEN_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // [7:0] rx_byte
  input  logic                 s_tuser,   // [0] operation
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [15:0]          m_tdata,   // [0] relay_on, [8:1] target_state, [15:9] zero
  output logic                 m_tuser,   // [0] frame_accepted
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TIMER_W-1:0]   cfg_data
);

  logic               in_valid;
  logic               in_op;
  logic [7:0]         in_byte;
  logic               advance;
  logic [TIMER_W-1:0] on_delay, hold_ms, timeout_ms;
  frame_t             frame;
  logic               relay_on;
  logic               res_relay;
  logic               res_acc;
  logic [7:0]         res_target;

  assign advance = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      on_delay <= ON_DELAY_RST;
      hold_ms <= HOLD_MS_RST;
      timeout_ms <= TIMEOUT_MS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ON_DELAY:   on_delay <= cfg_data;
        CFG_HOLD_MS:    hold_ms <= cfg_data;
        CFG_TIMEOUT_MS: timeout_ms <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op <= s_tuser;
      in_byte <= s_tdata;
    end
  end

  rfpr_parser #(
    .MaxDataLen(MAX_DATA_LEN)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .op        (in_op),
    .rx_byte   (in_byte),
    .timeout_ms(timeout_ms),
    .frame     (frame)
  );

  rfpr_presence u_presence (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .op        (in_op),
    .frame     (frame),
    .on_delay  (on_delay),
    .hold_ms   (hold_ms),
    .relay_on  (relay_on)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_relay <= relay_on;
      res_acc <= frame.accepted;
      res_target <= frame.target;
    end
  end

  assign m_tdata = {7'd0, res_target, res_relay};
  assign m_tuser = res_acc;

  a_no_target_without_frame: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> (m_tdata[8:1] == 8'd0))
    else $error("target state present without an accepted frame");

  a_accepted_item_held: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> in_valid)
    else $error("accepted transfer lost from the input stage");

  a_stalled_item_kept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_op) && $stable(in_byte))
    else $error("input stage changed while the result side stalled");

endmodule
